@@ src/tbht_pkg.sv @@
// Package for the tagged bucket hash table: request and response types,
// operation and status codes, controller states and control structs.
// No dependencies.
`timescale 1ns / 1ps

package tbht_pkg;

  localparam int unsigned MaxBucketsDef  = 16;
  localparam int unsigned SlotsPerBucket = 16;
  localparam int unsigned SlotW          = 4;
  localparam int unsigned KeyWidthDef    = 64;
  localparam int unsigned ValueWidthDef  = 32;
  localparam int unsigned H1TopBit       = 56;
  localparam int unsigned ModDigits      = 15;

  localparam logic [7:0] TagEmpty   = 8'h00;
  localparam logic [7:0] TagDeleted = 8'h80;
  localparam logic [7:0] TagZeroFix = 8'hFF;

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } tbht_op_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_ABSENT  = 2'd1,
    STS_PRESENT = 2'd2,
    STS_FULL    = 2'd3
  } tbht_status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_EVAL,
    ST_WRITE,
    ST_RESP
  } tbht_state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] key;
    logic [63:0] hash;
    logic [31:0] value;
  } tbht_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_value;
    logic [7:0]  slot_index;
    logic [8:0]  entry_count;
  } tbht_rsp_t;

  typedef struct packed {
    logic capture;
    logic mod_step;
    logic eval_en;
    logic write_en;
    logic respond;
    logic clear_step;
  } tbht_cmd_t;

  typedef struct packed {
    logic op_none;
    logic n_pow2;
    logic mod_done;
    logic eval_done;
    logic eval_write;
    logic clear_done;
    logic out_free;
  } tbht_sts_t;

endpackage

@@ src/tbht_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tbht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/tbht_ctrl.sv @@
// Controller state machine of the hash table: clearing, capture, bucket
// reduction, probing, the table update and the response. Uses tbht_pkg.
`timescale 1ns / 1ps

module tbht_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tbht_pkg::tbht_sts_t sts_i,
  output tbht_pkg::tbht_cmd_t cmd_o
);
  import tbht_pkg::*;

  tbht_state_e state_q, state_d;
  logic        accept;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (sts_i.op_none) state_d = ST_RESP;
          else if (sts_i.n_pow2) state_d = ST_READ;
          else state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        if (sts_i.mod_done) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (sts_i.eval_done) state_d = sts_i.eval_write ? ST_WRITE : ST_RESP;
        else state_d = ST_READ;
      end
      ST_WRITE: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_stall_o         = (state_q != ST_IDLE);
    cmd_o              = '0;
    cmd_o.capture      = accept;
    cmd_o.mod_step     = (state_q == ST_MOD);
    cmd_o.eval_en      = (state_q == ST_EVAL);
    cmd_o.write_en     = (state_q == ST_WRITE);
    cmd_o.respond      = (state_q == ST_RESP) && sts_i.out_free;
    cmd_o.clear_step   = (state_q == ST_CLEAR);
  end

endmodule

@@ src/tbht_dp.sv @@
// Datapath of the hash table: tag, key and value RAMs, probe sequence,
// slot matching, entry count, configuration and response register.
// Uses tbht_pkg and tbht_ram.
`timescale 1ns / 1ps

module tbht_dp #(
  parameter int unsigned MaxBuckets = tbht_pkg::MaxBucketsDef,
  parameter int unsigned KeyWidth   = tbht_pkg::KeyWidthDef,
  parameter int unsigned ValueWidth = tbht_pkg::ValueWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tbht_pkg::tbht_cmd_t cmd_i,
  output tbht_pkg::tbht_sts_t sts_o,
  input  tbht_pkg::tbht_req_t in_req_i,
  input  logic                cfg_valid_i,
  input  logic [2:0]          cfg_data_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output tbht_pkg::tbht_rsp_t out_rsp_o
);
  import tbht_pkg::*;

  localparam int unsigned BW = $clog2(MaxBuckets);
  localparam int unsigned NW = BW + 1;
  localparam int unsigned IW = BW + SlotW;
  localparam int unsigned LW = $clog2(MaxBuckets * SlotsPerBucket + 1);
  localparam int unsigned VW = (ValueWidth > 32) ? 32 : ValueWidth;
  localparam int unsigned HW = ModDigits * 4;
  localparam bit IsPow2 = ((MaxBuckets & (MaxBuckets - 1)) == 0);
  localparam logic [NW-1:0] MaxN = NW'(MaxBuckets);

  tbht_req_t     req_q;
  logic [7:0]    h2_q;
  logic [BW-1:0] bucket_q;
  logic [BW-1:0] probe_q;
  logic [BW-1:0] res_q;
  logic [3:0]    dig_q;
  logic          free_found_q;
  logic [IW-1:0] free_q;
  logic [IW-1:0] wslot_q;
  logic          wr_ins_q;
  tbht_status_e  status_q;
  logic [VW-1:0] fval_q;
  logic [IW-1:0] slotidx_q;
  logic [LW-1:0] live_q;
  logic [2:0]    lg_q;
  logic [BW-1:0] clr_q;
  logic          out_valid_q;
  tbht_rsp_t     rsp_q;

  logic [2:0]    lg_eff;
  logic [7:0]    pow;
  logic [NW-1:0] n;
  logic          n_pow2;
  logic [BW-1:0] mask;
  logic [7:0]    in_h2;

  logic [7:0]          tag_rd [SlotsPerBucket];
  logic [KeyWidth-1:0] key_rd [SlotsPerBucket];
  logic [VW-1:0]       val_rd [SlotsPerBucket];

  logic [SlotsPerBucket-1:0] tag_we;
  logic [SlotsPerBucket-1:0] kv_we;
  logic [BW-1:0]             wr_addr;
  logic [7:0]                tag_wdata;

  logic             all_empty;
  logic             hit;
  logic [SlotW-1:0] hit_s;
  logic             any_free;
  logic [SlotW-1:0] free_s;
  logic             last;
  logic [NW-1:0]    nb;
  logic [HW-1:0]    h1_ext;
  logic [3:0]       digit;
  logic [NW-1:0]    r2;
  logic [IW-1:0]    chosen;
  logic             have_free;
  logic             is_ins;
  logic             eval_done;
  logic             eval_write;

  always_comb begin
    lg_eff = (lg_q == 3'd0) ? 3'd1 : lg_q;
    pow    = 8'd1 << lg_eff;
    if (32'(pow) > MaxBuckets) begin
      n      = MaxN;
      n_pow2 = IsPow2;
    end else begin
      n      = NW'(pow);
      n_pow2 = 1'b1;
    end
    mask  = BW'(n - NW'(1));
    in_h2 = {1'b0, in_req_i.hash[63:57]};
    if (in_h2 == TagEmpty) in_h2 = TagZeroFix;
  end

  for (genvar s = 0; s < SlotsPerBucket; s++) begin : g_slot
    tbht_ram #(.Width(8), .Depth(MaxBuckets)) u_tag (
      .clk_i  (clk_i),
      .we_i   (tag_we[s]),
      .waddr_i(wr_addr),
      .wdata_i(tag_wdata),
      .raddr_i(bucket_q),
      .rdata_o(tag_rd[s])
    );
    tbht_ram #(.Width(KeyWidth), .Depth(MaxBuckets)) u_key (
      .clk_i  (clk_i),
      .we_i   (kv_we[s]),
      .waddr_i(wr_addr),
      .wdata_i(req_q.key[KeyWidth-1:0]),
      .raddr_i(bucket_q),
      .rdata_o(key_rd[s])
    );
    tbht_ram #(.Width(VW), .Depth(MaxBuckets)) u_val (
      .clk_i  (clk_i),
      .we_i   (kv_we[s]),
      .waddr_i(wr_addr),
      .wdata_i(req_q.value[VW-1:0]),
      .raddr_i(bucket_q),
      .rdata_o(val_rd[s])
    );
  end

  always_comb begin
    tag_we    = '0;
    kv_we     = '0;
    wr_addr   = wslot_q[IW-1:SlotW];
    tag_wdata = wr_ins_q ? h2_q : TagDeleted;
    if (cmd_i.clear_step) begin
      tag_we    = '1;
      wr_addr   = clr_q;
      tag_wdata = TagEmpty;
    end else if (cmd_i.write_en) begin
      tag_we[wslot_q[SlotW-1:0]] = 1'b1;
      kv_we[wslot_q[SlotW-1:0]]  = wr_ins_q;
    end
  end

  always_comb begin
    all_empty = 1'b1;
    hit       = 1'b0;
    hit_s     = '0;
    any_free  = 1'b0;
    free_s    = '0;
    for (int s = SlotsPerBucket - 1; s >= 0; s--) begin
      if (tag_rd[s] != TagEmpty) all_empty = 1'b0;
      if (tag_rd[s] == h2_q && key_rd[s] == req_q.key[KeyWidth-1:0]) begin
        hit   = 1'b1;
        hit_s = SlotW'(s);
      end
      if (tag_rd[s] == TagEmpty || tag_rd[s] == TagDeleted) begin
        any_free = 1'b1;
        free_s   = SlotW'(s);
      end
    end
    last = ({1'b0, probe_q} == n - NW'(1));
    nb   = {1'b0, bucket_q} + {1'b0, probe_q} + NW'(1);
    if (nb >= n) nb = nb - n;
    h1_ext = HW'(req_q.hash[H1TopBit:0]);
    digit  = h1_ext[{dig_q, 2'b00} +: 4];
    r2     = {1'b0, res_q};
    for (int k = 3; k >= 0; k--) begin
      r2 = {r2[NW-2:0], digit[k]};
      if (r2 >= n) r2 = r2 - n;
    end
    chosen    = free_found_q ? free_q : {bucket_q, free_s};
    have_free = free_found_q || any_free;
    is_ins    = (req_q.op == OP_INSERT);
    eval_done  = 1'b0;
    eval_write = 1'b0;
    if (is_ins) begin
      if (hit) begin
        eval_done = 1'b1;
      end else if (all_empty || last) begin
        eval_done  = 1'b1;
        eval_write = have_free;
      end
    end else begin
      if (all_empty) begin
        eval_done = 1'b1;
      end else if (hit) begin
        eval_done  = 1'b1;
        eval_write = (req_q.op == OP_REMOVE);
      end else if (last) begin
        eval_done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q        <= in_req_i;
      h2_q         <= in_h2;
      bucket_q     <= in_req_i.hash[BW-1:0] & mask;
      res_q        <= '0;
      dig_q        <= 4'(ModDigits - 1);
      probe_q      <= '0;
      free_found_q <= 1'b0;
      status_q     <= STS_ABSENT;
      fval_q       <= '0;
      slotidx_q    <= '0;
    end
    if (cmd_i.mod_step) begin
      res_q    <= BW'(r2);
      bucket_q <= BW'(r2);
      dig_q    <= dig_q - 4'd1;
    end
    if (cmd_i.eval_en) begin
      if (is_ins) begin
        if (hit) begin
          status_q  <= STS_PRESENT;
          slotidx_q <= {bucket_q, hit_s};
        end else begin
          if (!free_found_q && any_free) begin
            free_found_q <= 1'b1;
            free_q       <= {bucket_q, free_s};
          end
          if (eval_done) begin
            if (have_free) begin
              status_q  <= STS_OK;
              slotidx_q <= chosen;
              wslot_q   <= chosen;
              wr_ins_q  <= 1'b1;
            end else begin
              status_q <= STS_FULL;
            end
          end
        end
      end else if (!all_empty && hit) begin
        status_q  <= STS_OK;
        fval_q    <= val_rd[hit_s];
        slotidx_q <= {bucket_q, hit_s};
        wslot_q   <= {bucket_q, hit_s};
        wr_ins_q  <= 1'b0;
      end
      if (!eval_done) begin
        probe_q  <= probe_q + BW'(1);
        bucket_q <= BW'(nb);
      end
    end
    if (cmd_i.respond) begin
      rsp_q.status      <= status_q;
      rsp_q.found_value <= 32'(fval_q);
      rsp_q.slot_index  <= 8'(slotidx_q);
      rsp_q.entry_count <= 9'(live_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q      <= '0;
      lg_q        <= 3'd1;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_step) clr_q <= clr_q + BW'(1);
      if (cmd_i.write_en) begin
        if (wr_ins_q) live_q <= live_q + LW'(1);
        else if (live_q != '0) live_q <= live_q - LW'(1);
      end
      if (cfg_valid_i && live_q == '0) lg_q <= cfg_data_i;
      if (cmd_i.respond) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.op_none    = (in_req_i.op == OP_NONE);
    sts_o.n_pow2     = n_pow2;
    sts_o.mod_done   = (dig_q == 4'd0);
    sts_o.eval_done  = eval_done;
    sts_o.eval_write = eval_write;
    sts_o.clear_done = (clr_q == BW'(MaxBuckets - 1));
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

@@ src/tagged_bucket_hash_table_core.sv @@
// Top level of the tagged bucket hash table: joins controller and datapath.
// Uses tbht_pkg, tbht_ctrl and tbht_dp.
`timescale 1ns / 1ps

// Requests carry find, insert or remove with a key, a precomputed hash and a
// value; each request gives exactly one response with status, found value,
// slot index and entry count. A request is taken when in_valid_i is high and
// in_stall_o is low; a response is taken when out_valid_o is high and
// out_stall_i is low. The register write channel sets log2 of the active
// bucket count and takes effect only while the table is empty.
// After reset a clearing pass zeroes the tag RAMs one bucket per cycle, so no
// request is taken until it is done; configuration writes are taken at any
// time. For each probed bucket a request reads the bucket and then compares
// all 16 slots; capture comes before the probes, and an update of the table,
// if any, and the response come after them. A request with the unused op
// code goes from capture straight to the response. When the bucket count is
// not a power of two the home bucket is first reduced four hash bits per
// cycle. The next request may be taken while a response waits; a stalled
// receiver holds back only the following response.
module tagged_bucket_hash_table_core #(
  parameter int unsigned MaxBuckets = tbht_pkg::MaxBucketsDef,
  parameter int unsigned KeyWidth   = tbht_pkg::KeyWidthDef,
  parameter int unsigned ValueWidth = tbht_pkg::ValueWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tbht_pkg::tbht_req_t in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tbht_pkg::tbht_rsp_t out_rsp_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_data_i
);
  import tbht_pkg::*;

  tbht_cmd_t cmd;
  tbht_sts_t sts;

  assign cfg_ready_o = 1'b1;

  tbht_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  tbht_dp #(
    .MaxBuckets(MaxBuckets),
    .KeyWidth  (KeyWidth),
    .ValueWidth(ValueWidth)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_req_i   (in_req_i),
    .cfg_valid_i(cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_rsp_o  (out_rsp_o)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("Block took a request without going busy.");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_rsp_o.entry_count) <= MaxBuckets * SlotsPerBucket))
    else $error("Entry count exceeds the table size.");

  a_value_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.found_value != '0) |-> (out_rsp_o.status == STS_OK))
    else $error("Nonzero value reported without a hit.");
`endif

endmodule
